@@ hw/rtl/tws_pkg.sv @@
// ----------------------------------------------------------------------------
// tws_pkg
// shared constants and helpers for the three-wire serial master
// ----------------------------------------------------------------------------
package tws_pkg;

   // request and response bus widths
   localparam int REQ_DATA_W = 80;   // 74 payload bits padded to bytes
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 72;   // 70 payload bits padded to bytes

   // configuration register indexes
   localparam logic CSR_BIT_DELAY   = 1'b0;
   localparam logic CSR_FRAME_DELAY = 1'b1;

   localparam logic [15:0] BIT_DELAY_RESET   = 16'd16;
   localparam logic [15:0] FRAME_DELAY_RESET = 16'd64;

   // operation codes
   localparam logic [1:0] OP_SINGLE_WRITE = 2'd0;
   localparam logic [1:0] OP_BURST_WRITE  = 2'd1;
   localparam logic [1:0] OP_BURST_READ   = 2'd2;

   // sequencer phases
   localparam logic [3:0] PH_IDLE  = 4'd0;
   localparam logic [3:0] PH_SETUP = 4'd1;
   localparam logic [3:0] PH_WBIT  = 4'd2;
   localparam logic [3:0] PH_WHIGH = 4'd3;
   localparam logic [3:0] PH_WLOW  = 4'd4;
   localparam logic [3:0] PH_RHIGH = 4'd5;
   localparam logic [3:0] PH_RLOW  = 4'd6;
   localparam logic [3:0] PH_HOLD  = 4'd7;

   // data bytes per transfer: 8 for a burst, 1 for a single write
   localparam logic [3:0] BURST_BYTES    = 4'd8;
   localparam logic [3:0] SINGLE_BYTES   = 4'd1;
   localparam logic [2:0] LAST_BIT       = 3'd7;
   localparam logic [7:0] CMD_WRITE_MASK = 8'hFE;

   // a zero delay counts as one tick
   function automatic logic [15:0] eff_delay(input logic [15:0] v);
      return (v == 16'd0) ? 16'd1 : v;
   endfunction

   // bit to put on the line: command byte first, then the data bytes
   function automatic logic sel_bit(input logic [7:0]  cmd,
                                    input logic [63:0] shift,
                                    input logic [3:0]  byte_idx,
                                    input logic [2:0]  bit_idx);
      logic [3:0]  bm1;
      logic [63:0] sh;
      logic [7:0]  b;
      bm1 = byte_idx - 4'd1;
      sh  = shift >> {bm1[2:0], 3'b000};
      b   = (byte_idx == 4'd0) ? cmd : sh[7:0];
      return b[bit_idx];
   endfunction

endpackage

@@ hw/rtl/three_wire_serial_master_core.sv @@
// ----------------------------------------------------------------------------
// three_wire_serial_master_core
// lsb-first three-wire serial master, one request per engine tick
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              contents
//  req      in         req_tvalid/req_tready  tick: start, command, data, pin
//  rsp      out        rsp_tvalid/rsp_tready  pin levels, busy, done, read data
//  csr      in         csr_we                 bit and frame delay registers
//
//  every accepted request is one tick of the serial engine and gives one
//  response; one request per cycle is sustained while each response is
//  taken, through a single next-state pass from phase to response register
//  response appears the cycle after acceptance in an output register
//  a stalled response still lets one more request be taken when rsp_tready
//  is high in the same cycle; otherwise req_tready drops until it is taken
//  synchronous reset puts the engine idle with all pins low, data driven
//
module three_wire_serial_master_core (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [0] start_req, [8:1] command, [72:9] write_data, [73] dat_in
   input  logic [tws_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] op
   input  logic [tws_pkg::REQ_USER_W-1:0] req_tuser,
   // response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [0] ce_out, [1] sclk_out, [2] io_out, [3] io_drive, [4] busy_res,
   // [5] done_res, [69:6] read_data
   output logic [tws_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // configuration port
   input  logic                           csr_we,
   input  logic                           csr_index,
   input  logic [15:0]                    csr_wdata
);
   import tws_pkg::*;

   // request fields
   logic        start_req;
   logic [1:0]  op;
   logic [7:0]  command;
   logic [63:0] write_data;
   logic        dat_in;
   logic        req_accept;

   // configuration registers
   logic [15:0] bit_delay_ff,   bit_delay_in;
   logic [15:0] frame_delay_ff, frame_delay_in;

   // engine state
   logic [3:0]  phase_ff,       phase_in;
   logic [2:0]  bit_idx_ff,     bit_idx_in;
   logic [3:0]  byte_idx_ff,    byte_idx_in;
   logic [15:0] delay_ff,       delay_in;
   logic [63:0] send_shift_ff,  send_shift_in;
   logic [63:0] recv_shift_ff,  recv_shift_in;
   logic [7:0]  cmd_byte_ff,    cmd_byte_in;
   logic [1:0]  saved_op_ff,    saved_op_in;
   logic        ce_ff,          ce_in;
   logic        sclk_ff,        sclk_in;
   logic        io_ff,          io_in;
   logic        drive_ff,       drive_in;
   logic        done_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff,  rsp_data_in;

   // bit advance helpers
   logic [3:0]  byte_next;
   logic [3:0]  byte_count;
   logic [2:0]  adv_bit;
   logic [3:0]  adv_byte;
   logic        adv_last;
   logic        adv_out_bit;
   logic        cur_out_bit;
   logic [3:0]  rd_byte_m1;
   logic [5:0]  rd_pos;

   assign start_req  = req_tdata[0];
   assign command    = req_tdata[8:1];
   assign write_data = req_tdata[72:9];
   assign dat_in     = req_tdata[73];
   assign op         = req_tuser[1:0];

   // output register frees up when empty or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   // ---------------------------------------------------------------
   // configuration writes
   // ---------------------------------------------------------------
   always_comb begin
      bit_delay_in   = bit_delay_ff;
      frame_delay_in = frame_delay_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BIT_DELAY:   bit_delay_in   = csr_wdata;
            CSR_FRAME_DELAY: frame_delay_in = csr_wdata;
            default: begin
               bit_delay_in   = bit_delay_ff;
               frame_delay_in = frame_delay_ff;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // bit and byte advance, used at the end of each bit
   // ---------------------------------------------------------------
   assign byte_count = (saved_op_ff == OP_SINGLE_WRITE) ? SINGLE_BYTES : BURST_BYTES;
   assign byte_next  = byte_idx_ff + 4'd1;

   always_comb begin
      if (bit_idx_ff != LAST_BIT) begin
         adv_bit  = bit_idx_ff + 3'd1;
         adv_byte = byte_idx_ff;
         adv_last = 1'b0;
      end else begin
         adv_bit  = 3'd0;
         adv_byte = byte_next;
         adv_last = byte_next > byte_count;
      end
   end

   // line level for the first bit and for the bit after an advance
   assign cur_out_bit = sel_bit(cmd_byte_ff, send_shift_ff, byte_idx_ff, bit_idx_ff);
   assign adv_out_bit = sel_bit(cmd_byte_ff, send_shift_ff, adv_byte, adv_bit);

   // receive position of the bit being sampled
   assign rd_byte_m1 = byte_idx_ff - 4'd1;
   assign rd_pos     = {rd_byte_m1[2:0], bit_idx_ff};

   // ---------------------------------------------------------------
   // engine next state, one tick per request
   // ---------------------------------------------------------------
   always_comb begin
      phase_in      = phase_ff;
      bit_idx_in    = bit_idx_ff;
      byte_idx_in   = byte_idx_ff;
      delay_in      = delay_ff;
      send_shift_in = send_shift_ff;
      recv_shift_in = recv_shift_ff;
      cmd_byte_in   = cmd_byte_ff;
      saved_op_in   = saved_op_ff;
      ce_in         = ce_ff;
      sclk_in       = sclk_ff;
      io_in         = io_ff;
      drive_in      = drive_ff;
      done_in       = 1'b0;

      if (phase_ff == PH_IDLE) begin
         // opcode 3 is ignored
         if (start_req && (op == OP_SINGLE_WRITE || op == OP_BURST_WRITE ||
                           op == OP_BURST_READ)) begin
            saved_op_in   = op;
            cmd_byte_in   = (op == OP_SINGLE_WRITE) ? (command & CMD_WRITE_MASK)
                                                    : command;
            send_shift_in = write_data;
            if (op == OP_BURST_READ) begin
               recv_shift_in = 64'd0;
            end
            bit_idx_in  = 3'd0;
            byte_idx_in = 4'd0;
            ce_in       = 1'b1;
            sclk_in     = 1'b0;
            drive_in    = 1'b1;
            phase_in    = PH_SETUP;
            delay_in    = eff_delay(frame_delay_ff);
         end
      end else if (delay_ff > 16'd1) begin
         delay_in = delay_ff - 16'd1;
      end else begin
         case (phase_ff)
            PH_SETUP: begin
               // indices are zero here: first command bit
               io_in    = cur_out_bit;
               drive_in = 1'b1;
               phase_in = PH_WBIT;
               delay_in = eff_delay(bit_delay_ff);
            end
            PH_WBIT: begin
               sclk_in  = 1'b1;
               phase_in = PH_WHIGH;
               delay_in = eff_delay(bit_delay_ff);
            end
            PH_WHIGH: begin
               // turnaround: release data while clock is still high
               if (saved_op_ff == OP_BURST_READ && byte_idx_ff == 4'd0 &&
                   bit_idx_ff == LAST_BIT) begin
                  drive_in    = 1'b0;
                  byte_idx_in = 4'd1;
                  bit_idx_in  = 3'd0;
                  phase_in    = PH_RHIGH;
               end else begin
                  sclk_in  = 1'b0;
                  phase_in = PH_WLOW;
               end
               delay_in = eff_delay(bit_delay_ff);
            end
            PH_WLOW: begin
               bit_idx_in  = adv_bit;
               byte_idx_in = adv_byte;
               if (adv_last) begin
                  ce_in    = 1'b0;
                  phase_in = PH_HOLD;
                  delay_in = eff_delay(frame_delay_ff);
               end else begin
                  io_in    = adv_out_bit;
                  drive_in = 1'b1;
                  phase_in = PH_WBIT;
                  delay_in = eff_delay(bit_delay_ff);
               end
            end
            PH_RHIGH: begin
               sclk_in  = 1'b0;
               phase_in = PH_RLOW;
               delay_in = eff_delay(bit_delay_ff);
            end
            PH_RLOW: begin
               recv_shift_in[rd_pos] = dat_in;
               bit_idx_in  = adv_bit;
               byte_idx_in = adv_byte;
               if (adv_last) begin
                  ce_in    = 1'b0;
                  phase_in = PH_HOLD;
                  delay_in = eff_delay(frame_delay_ff);
               end else begin
                  sclk_in  = 1'b1;
                  phase_in = PH_RHIGH;
                  delay_in = eff_delay(bit_delay_ff);
               end
            end
            PH_HOLD: begin
               phase_in = PH_IDLE;
               delay_in = 16'd0;
               done_in  = 1'b1;
            end
            default: begin
               phase_in = PH_IDLE;
               delay_in = 16'd0;
            end
         endcase
      end
   end

   // response word from the updated state
   assign rsp_data_in = {2'b00, recv_shift_in, done_in, (phase_in != PH_IDLE),
                         drive_in, io_in, sclk_in, ce_in};

   // response valid: loads on a request, clears once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_delay_ff   <= BIT_DELAY_RESET;
         frame_delay_ff <= FRAME_DELAY_RESET;
         phase_ff       <= PH_IDLE;
         bit_idx_ff     <= 3'd0;
         byte_idx_ff    <= 4'd0;
         delay_ff       <= 16'd0;
         send_shift_ff  <= 64'd0;
         recv_shift_ff  <= 64'd0;
         cmd_byte_ff    <= 8'd0;
         saved_op_ff    <= OP_SINGLE_WRITE;
         ce_ff          <= 1'b0;
         sclk_ff        <= 1'b0;
         io_ff          <= 1'b0;
         drive_ff       <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         bit_delay_ff   <= bit_delay_in;
         frame_delay_ff <= frame_delay_in;
         rsp_valid_ff   <= rsp_valid_in;
         // engine only ticks on an accepted request
         if (req_accept) begin
            phase_ff      <= phase_in;
            bit_idx_ff    <= bit_idx_in;
            byte_idx_ff   <= byte_idx_in;
            delay_ff      <= delay_in;
            send_shift_ff <= send_shift_in;
            recv_shift_ff <= recv_shift_in;
            cmd_byte_ff   <= cmd_byte_in;
            saved_op_ff   <= saved_op_in;
            ce_ff         <= ce_in;
            sclk_ff       <= sclk_in;
            io_ff         <= io_in;
            drive_ff      <= drive_in;
         end
      end
   end

   // response payload holds while stalled
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------

   // a running phase always has a pending delay of at least one tick
   a_delay_live: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> (delay_ff != 16'd0))
      else $error("active phase with zero delay count");

   // byte counter never runs past the last burst byte plus one
   a_byte_range: assert property (@(posedge clock) disable iff (reset)
      byte_idx_ff <= (BURST_BYTES + 4'd1))
      else $error("byte index out of range");

   // data line is released only by a burst read
   a_release_read: assert property (@(posedge clock) disable iff (reset)
      !drive_ff |-> (saved_op_ff == OP_BURST_READ))
      else $error("data line released outside a burst read");

   // done pulse lands together with the engine going idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[5]) |-> !rsp_data_ff[4])
      else $error("done reported while busy");

endmodule
